/* rtl/scatr_pkg.sv */
package scatr_pkg;

  localparam int unsigned MaxAtrLen = 32;
  localparam int unsigned IdxW      = 6;

  localparam logic [7:0] TsDirect  = 8'h3B;
  localparam logic [7:0] TsInverse = 8'hC0;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DONE     = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_INVERSE  = 3'd3,
    ST_INVALID  = 3'd4,
    ST_INACTIVE = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_atr;
  } item_t;

  typedef struct packed {
    status_t         status;
    logic [IdxW-1:0] byte_index;
  } result_t;

endpackage

/* rtl/smartcard_atr_parser_unit.sv */
// Channel  | Signals                                 | Payload
// ---------+-----------------------------------------+--------------------------
// item     | item_valid, item_ready, item            | rx_byte, new_atr
// result   | result_valid, result_ready, result      | status, byte_index
//
// Each byte yields exactly one result, registered when the byte is accepted.
// A new byte is accepted in every cycle while the result register is empty
// or being drained, so throughput is one byte per cycle.
// Reset (rst, synchronous) empties the result register and leaves the parser
// inactive until a byte arrives with new_atr set.
// A stalled result holds item_ready low; no state changes while stalled.
module smartcard_atr_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  scatr_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output scatr_pkg::result_t result
);
  import scatr_pkg::*;

  typedef enum logic [7:0] {
    PH_IDLE = 8'b0000_0001,
    PH_TS   = 8'b0000_0010,
    PH_T0   = 8'b0000_0100,
    PH_TA   = 8'b0000_1000,
    PH_TB   = 8'b0001_0000,
    PH_TC   = 8'b0010_0000,
    PH_TD   = 8'b0100_0000,
    PH_TAIL = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    status_t    status;
    logic [4:0] tail;
  } adv_t;

  phase_t          phase, phase_next;
  logic [7:0]      current_td, current_td_next;
  logic [3:0]      hist_count, hist_count_next;
  logic [4:0]      tail_remaining, tail_remaining_next;
  logic [IdxW-1:0] length_count, length_count_next;
  logic            tck_needed, tck_needed_next;
  result_t         result_next;
  logic            accept;

  // Picks the next expected interface byte from the Y bits, starting at
  // the given position, or moves on to the historical bytes and TCK, or ends the ATR.
  function automatic adv_t advance(input logic [7:0] td, input logic [1:0] first,
                                   input logic [3:0] hist, input logic tck,
                                   input logic [4:0] tail_in);
    adv_t r;
    r.tail   = tail_in;
    r.status = ST_OK;
    if (first == 2'd0 && td[4]) begin
      r.phase = PH_TA;
    end else if (first <= 2'd1 && td[5]) begin
      r.phase = PH_TB;
    end else if (first <= 2'd2 && td[6]) begin
      r.phase = PH_TC;
    end else if (td[7]) begin
      r.phase = PH_TD;
    end else begin
      r.tail = 5'({1'b0, hist} + 5'(tck));
      if (r.tail != 5'd0) begin
        r.phase = PH_TAIL;
      end else begin
        r.phase  = PH_IDLE;
        r.status = ST_DONE;
      end
    end
    return r;
  endfunction

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  always_comb begin
    phase_t          ph;
    logic [7:0]      td;
    logic [3:0]      hist;
    logic [4:0]      tail;
    logic [IdxW-1:0] len;
    logic            tck;
    adv_t            a;

    ph   = phase;
    td   = current_td;
    hist = hist_count;
    tail = tail_remaining;
    len  = length_count;
    tck  = tck_needed;
    if (item.new_atr) begin
      ph   = PH_TS;
      td   = '0;
      hist = '0;
      tail = '0;
      len  = '0;
      tck  = 1'b0;
    end

    a = '{phase: ph, status: ST_OK, tail: tail};

    phase_next             = ph;
    current_td_next        = td;
    hist_count_next        = hist;
    tail_remaining_next    = tail;
    length_count_next      = len;
    tck_needed_next        = tck;
    result_next.status     = ST_OK;
    result_next.byte_index = len;

    if (ph == PH_IDLE) begin
      result_next.status     = ST_INACTIVE;
      result_next.byte_index = '0;
    end else if (len >= IdxW'(MaxAtrLen)) begin
      phase_next             = PH_IDLE;
      result_next.status     = ST_OVERFLOW;
      result_next.byte_index = IdxW'(MaxAtrLen);
    end else begin
      length_count_next = len + IdxW'(1);
      case (ph)
        PH_TS: begin
          if (item.rx_byte == TsDirect) begin
            phase_next = PH_T0;
          end else if (item.rx_byte == TsInverse) begin
            phase_next         = PH_IDLE;
            result_next.status = ST_INVERSE;
          end else begin
            phase_next         = PH_IDLE;
            result_next.status = ST_INVALID;
          end
        end
        PH_T0: begin
          current_td_next = item.rx_byte;
          hist_count_next = item.rx_byte[3:0];
          a = advance(item.rx_byte, 2'd0, item.rx_byte[3:0], tck, tail);
        end
        PH_TD: begin
          current_td_next = item.rx_byte;
          tck_needed_next = tck || (item.rx_byte[3:0] != 4'd0);
          a = advance(item.rx_byte, 2'd0, hist, tck_needed_next, tail);
        end
        PH_TA: a = advance(td, 2'd1, hist, tck, tail);
        PH_TB: a = advance(td, 2'd2, hist, tck, tail);
        PH_TC: a = advance(td, 2'd3, hist, tck, tail);
        PH_TAIL: begin
          a.tail = (tail != 5'd0) ? tail - 5'd1 : tail;
          if (a.tail != 5'd0) begin
            a.phase = PH_TAIL;
          end else begin
            a.phase  = PH_IDLE;
            a.status = ST_DONE;
          end
        end
        default: a = '{phase: PH_IDLE, status: ST_INACTIVE, tail: tail};
      endcase
      if (ph != PH_TS) begin
        phase_next          = a.phase;
        tail_remaining_next = a.tail;
        result_next.status  = a.status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      current_td     <= '0;
      hist_count     <= '0;
      tail_remaining <= '0;
      length_count   <= '0;
      tck_needed     <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        current_td     <= current_td_next;
        hist_count     <= hist_count_next;
        tail_remaining <= tail_remaining_next;
        length_count   <= length_count_next;
        tck_needed     <= tck_needed_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

/* tb/smartcard_atr_checker.sv */
module smartcard_atr_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_ready,
  input  scatr_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  scatr_pkg::result_t result,
  output int                 fail_count,
  output int                 outstanding
);

  import scatr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    P_IDLE,
    P_TS,
    P_T0,
    P_TA,
    P_TB,
    P_TC,
    P_TD,
    P_TAIL
  } atr_phase_e;

  atr_phase_e atr_phase;
  logic [7:0] cur_td;
  logic [3:0] hist_k;
  logic [4:0] tail_left;
  logic [5:0] atr_len;
  logic       tck_flag;

  result_t    due_results[$];
  int         fails;

  initial begin
    fails = 0;
  end

  task automatic clear_parser();
    atr_phase = P_IDLE;
    cur_td    = '0;
    hist_k    = '0;
    tail_left = '0;
    atr_len   = '0;
    tck_flag  = 1'b0;
  endtask

  // Looks for the next present interface byte starting at field 'first'
  // (TA, TB, TC, TD); with none left, the tail or the end of the ATR follows.
  task automatic pick_next(input int first, output status_t st);
    int b;
    bit hit;
    hit = 1'b0;
    for (b = first; b < 4; b++) begin
      if (!hit && cur_td[4+b]) begin
        hit = 1'b1;
        case (b)
          0: atr_phase = P_TA;
          1: atr_phase = P_TB;
          2: atr_phase = P_TC;
          default: atr_phase = P_TD;
        endcase
      end
    end
    st = ST_OK;
    if (!hit) begin
      tail_left = 5'(hist_k) + 5'(tck_flag);
      if (tail_left != 5'd0) begin
        atr_phase = P_TAIL;
      end else begin
        atr_phase = P_IDLE;
        st = ST_DONE;
      end
    end
  endtask

  task automatic parse_atr_byte(input item_t it, output result_t r);
    status_t st;
    st = ST_OK;
    if (it.new_atr) begin
      clear_parser();
      atr_phase = P_TS;
    end
    if (atr_phase == P_IDLE) begin
      r.status = ST_INACTIVE;
      r.byte_index = '0;
    end else if (atr_len >= IdxW'(MaxAtrLen)) begin
      atr_phase = P_IDLE;
      r.status = ST_OVERFLOW;
      r.byte_index = IdxW'(MaxAtrLen);
    end else begin
      r.byte_index = atr_len;
      atr_len = atr_len + 6'd1;
      case (atr_phase)
        P_TS: begin
          if (it.rx_byte == TsDirect) begin
            atr_phase = P_T0;
            st = ST_OK;
          end else if (it.rx_byte == TsInverse) begin
            atr_phase = P_IDLE;
            st = ST_INVERSE;
          end else begin
            atr_phase = P_IDLE;
            st = ST_INVALID;
          end
        end
        P_T0: begin
          cur_td = it.rx_byte;
          hist_k = it.rx_byte[3:0];
          pick_next(0, st);
        end
        P_TD: begin
          cur_td = it.rx_byte;
          if (it.rx_byte[3:0] != 4'h0) begin
            tck_flag = 1'b1;
          end
          pick_next(0, st);
        end
        P_TA: pick_next(1, st);
        P_TB: pick_next(2, st);
        P_TC: pick_next(3, st);
        default: begin
          if (tail_left != 5'd0) begin
            tail_left = tail_left - 5'd1;
          end
          if (tail_left != 5'd0) begin
            st = ST_OK;
          end else begin
            atr_phase = P_IDLE;
            st = ST_DONE;
          end
        end
      endcase
      r.status = st;
    end
  endtask

  // A result transaction can never belong to an item taken at the same edge,
  // so results are checked before the new expectation is queued.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_parser();
      due_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $error("result transaction with nothing expected: status %0d, byte_index %0d",
                 result.status, result.byte_index);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, result.status);
            fails++;
          end
          if (result.byte_index !== want.byte_index) begin
            $error("byte_index mismatch: expected %0d, actual %0d",
                   want.byte_index, result.byte_index);
            fails++;
          end
        end
      end
      if (item_valid && item_ready) begin
        parse_atr_byte(item, want);
        due_results.push_back(want);
      end
    end
    outstanding <= due_results.size();
    fail_count <= fails;
  end

endmodule

/* tb/tb_smartcard_atr_parser_unit.sv */
module tb_smartcard_atr_parser_unit;

  import scatr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  int      fail_count;
  int      outstanding;
  int      burst_left;
  int      bytes_sent;

  smartcard_atr_parser_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  smartcard_atr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // The receiver switches at random between stall patterns.
  initial begin
    int mode;
    int span;
    result_ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: result_ready <= 1'b1;
          1: result_ready <= $urandom_range(0, 1);
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start_atr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= '{rx_byte: b, new_atr: start_atr};
    do @(posedge clk); while (!item_ready);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] frame[$], input int cut);
    int i;
    for (i = 0; i < frame.size() && i < cut; i++) begin
      send_byte(frame[i], i == 0);
    end
  endtask

  // Builds a well-formed ATR with random interface, historical and TCK bytes.
  task automatic build_atr(output logic [7:0] frame[$]);
    logic [7:0] t0;
    logic [7:0] td;
    logic [3:0] y;
    int depth;
    int k;
    bit need_tck;
    frame.delete();
    frame.push_back(TsDirect);
    t0[7:4] = ($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom);
    t0[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
    frame.push_back(t0);
    y = t0[7:4];
    depth = 0;
    need_tck = 1'b0;
    while (y != 4'h0) begin
      if (y[0]) frame.push_back(8'($urandom));
      if (y[1]) frame.push_back(8'($urandom));
      if (y[2]) frame.push_back(8'($urandom));
      if (y[3]) begin
        td = 8'($urandom);
        if ($urandom_range(0, 1) == 0) td[3:0] = 4'h0;
        if (depth >= 3) td[7:4] = 4'h0;
        if (td[3:0] != 4'h0) need_tck = 1'b1;
        frame.push_back(td);
        y = td[7:4];
        depth++;
      end else begin
        y = 4'h0;
      end
    end
    for (k = 0; k < t0[3:0]; k++) begin
      frame.push_back(8'($urandom));
    end
    if (need_tck) frame.push_back(8'($urandom));
  endtask

  task automatic send_random_sequence();
    logic [7:0] frame[$];
    int kind;
    int n;
    int i;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end else if (kind == 1) begin
      send_byte(($urandom_range(0, 2) == 0) ? TsInverse : 8'($urandom), 1'b1);
    end else if (kind == 2) begin
      frame.delete();
      frame.push_back(TsDirect);
      n = $urandom_range(MaxAtrLen + 1, MaxAtrLen + 3);
      for (i = 1; i < n; i++) begin
        frame.push_back(8'($urandom) | 8'h80);
      end
      send_frame(frame, n);
    end else begin
      build_atr(frame);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : frame.size();
      send_frame(frame, n);
    end
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    burst_left = 0;
    bytes_sent = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Inactive parser after reset, then each TS outcome.
    send_byte(TsDirect, 1'b0);
    send_byte(TsInverse, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // Shortest ATR: no interface bytes, no historical bytes.
    send_byte(TsDirect, 1'b1);
    send_byte(8'h00, 1'b0);
    // All interface bytes, protocol T=1 in TD1 so TCK follows one historical byte.
    send_byte(TsDirect, 1'b1);
    send_byte(8'hF1, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hCC, 1'b0);
    // T0 carries a nonzero K but only T=0 appears in TD, so no TCK.
    send_byte(TsDirect, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);

    while (bytes_sent < 1300) begin
      send_random_sequence();
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
